FILE: src/xsr_pkg.sv
// Package with the constants and controller/datapath interface types of the bounded xorshift64* generator.
`timescale 1ns / 1ps
`default_nettype none
package xsr_pkg;

  localparam int VALUE_W = 64;
  localparam int BOUND_W = 32;
  localparam int HALF_W  = 32;
  localparam int MOD_STEPS = VALUE_W;
  localparam int CNT_W = $clog2(MOD_STEPS);

  localparam logic [VALUE_W-1:0] MULT_CONST    = 64'h2545F4914F6CDD1D;
  localparam logic [VALUE_W-1:0] ZERO_FALLBACK = 64'h9E3779B97F4A7C15;
  localparam int SHIFT_A = 12;
  localparam int SHIFT_B = 25;
  localparam int SHIFT_C = 27;

  // Operation codes carried in tuser.
  localparam logic OP_RAW     = 1'b0;
  localparam logic OP_BOUNDED = 1'b1;

  // Partial product selection for the shared 32x32 multiplier.
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       advance;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       mod_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic bounded;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/xsr_ctrl.sv
// Controller state machine sequencing the xorshift, multiply and modulo steps.
`timescale 1ns / 1ps
`default_nettype none
module xsr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  xsr_pkg::sts_t      sts,
  output xsr_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_XOR  = 3'd1;
  localparam logic [2:0] ST_MUL0 = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_MOD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                state, state_next;
  logic [xsr_pkg::CNT_W-1:0] count, count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.skip ? ST_DONE : ST_XOR;
        end
      end
      ST_XOR: begin
        cmd.advance = 1'b1;
        state_next  = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = xsr_pkg::MUL_LL;
        state_next  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = xsr_pkg::MUL_LH;
        state_next  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = xsr_pkg::MUL_HL;
        state_next  = sts.bounded ? ST_MOD : ST_DONE;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (count == xsr_pkg::CNT_W'(xsr_pkg::MOD_STEPS - 1)) begin
          count_next = '0;
          state_next = ST_DONE;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/xsr_dp.sv
// Datapath: generator state, xorshift step, shared multiplier, radix-2 modulo and output register.
`timescale 1ns / 1ps
`default_nettype none
module xsr_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [xsr_pkg::VALUE_W-1:0]  cfg_data,
  input  wire logic                         in_op,
  input  wire logic [xsr_pkg::BOUND_W-1:0]  in_bound,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [xsr_pkg::VALUE_W-1:0]       out_data,
  input  xsr_pkg::cmd_t                     cmd,
  output xsr_pkg::sts_t                     sts
);

  logic [xsr_pkg::VALUE_W-1:0] gen_state;
  logic [xsr_pkg::VALUE_W-1:0] xs_a, xs_b, xs_c;
  logic                        op;
  logic [xsr_pkg::BOUND_W-1:0] bound;
  logic [xsr_pkg::VALUE_W-1:0] prod;
  logic [xsr_pkg::BOUND_W-1:0] rem;
  logic [xsr_pkg::HALF_W-1:0]  mul_a, mul_b;
  logic [xsr_pkg::VALUE_W-1:0] mul_p;
  logic [xsr_pkg::BOUND_W:0]   rem_sh;
  logic [xsr_pkg::BOUND_W:0]   rem_sub;

  assign xs_a = gen_state ^ (gen_state >> xsr_pkg::SHIFT_A);
  assign xs_b = xs_a ^ (xs_a << xsr_pkg::SHIFT_B);
  assign xs_c = xs_b ^ (xs_b >> xsr_pkg::SHIFT_C);

  assign mul_a = (cmd.mul_sel == xsr_pkg::MUL_HL) ? gen_state[xsr_pkg::VALUE_W-1:xsr_pkg::HALF_W]
                                                  : gen_state[xsr_pkg::HALF_W-1:0];
  assign mul_b = (cmd.mul_sel == xsr_pkg::MUL_LH)
                 ? xsr_pkg::MULT_CONST[xsr_pkg::VALUE_W-1:xsr_pkg::HALF_W]
                 : xsr_pkg::MULT_CONST[xsr_pkg::HALF_W-1:0];
  assign mul_p = {{xsr_pkg::HALF_W{1'b0}}, mul_a} * {{xsr_pkg::HALF_W{1'b0}}, mul_b};

  assign rem_sh  = {rem, prod[xsr_pkg::VALUE_W-1]};
  assign rem_sub = rem_sh - {1'b0, bound};

  assign sts.skip     = (in_op == xsr_pkg::OP_BOUNDED) && (in_bound == '0);
  assign sts.bounded  = (op == xsr_pkg::OP_BOUNDED);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= xsr_pkg::ZERO_FALLBACK;
    end else if (cfg_valid) begin
      gen_state <= (cfg_data == '0) ? xsr_pkg::ZERO_FALLBACK : cfg_data;
    end else if (cmd.advance) begin
      gen_state <= xs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= in_op;
      bound <= in_bound;
      rem   <= '0;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_sel == xsr_pkg::MUL_LL) begin
        prod <= mul_p;
      end else begin
        prod[xsr_pkg::VALUE_W-1:xsr_pkg::HALF_W] <=
          prod[xsr_pkg::VALUE_W-1:xsr_pkg::HALF_W] + mul_p[xsr_pkg::HALF_W-1:0];
      end
    end
    if (cmd.mod_step) begin
      prod <= {prod[xsr_pkg::VALUE_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, bound}) begin
        rem <= rem_sub[xsr_pkg::BOUND_W-1:0];
      end else begin
        rem <= rem_sh[xsr_pkg::BOUND_W-1:0];
      end
    end
    if (cmd.load_out) begin
      out_data <= sts.bounded ? {{(xsr_pkg::VALUE_W-xsr_pkg::BOUND_W){1'b0}}, rem} : prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: src/xorshift64star_bounded_rng.sv
// Top level of the bounded xorshift64* random generator.
//
// Each input beat asks for one draw and yields exactly one output beat. A raw draw
// (tuser 0) runs one xorshift step and then three passes through a single shared
// 32x32 multiplier before the result beat. A bounded draw (tuser 1) adds a radix-2
// restoring modulo of 64 steps, one quotient bit per cycle. A bounded draw with a
// zero bound answers 0 and leaves the state alone. One draw is in flight at a time;
// a finished result waits in the output register, so a new beat is accepted while it
// is still unread. Writing the seed reloads the state at once (a zero seed loads the
// fallback constant) and is intended only while idle.
`timescale 1ns / 1ps
`default_nettype none
module xorshift64star_bounded_rng (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [xsr_pkg::VALUE_W-1:0]  cfg_data,      // seed
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [xsr_pkg::BOUND_W-1:0]  s_axis_tdata,  // upper_bound
  input  wire logic                         s_axis_tuser,  // operation
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [xsr_pkg::VALUE_W-1:0]       m_axis_tdata   // value
);

  xsr_pkg::cmd_t cmd;
  xsr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  xsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_op     (s_axis_tuser),
    .in_bound  (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

FILE: src/xsr_chk.sv
// Port-level checker for the bounded xorshift64* generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module xsr_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [xsr_pkg::BOUND_W-1:0]  s_axis_tdata,
  input wire logic                         s_axis_tuser,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [xsr_pkg::VALUE_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a draw is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result beat appeared without a draw in progress");

  a_zero_bound: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == xsr_pkg::OP_BOUNDED)
      && (s_axis_tdata == '0) && !m_axis_tvalid
      |-> ##2 m_axis_tvalid && (m_axis_tdata == '0))
    else $error("zero-bound draw did not answer zero");

endmodule

bind xorshift64star_bounded_rng xsr_chk u_xsr_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
